>>> sv/jfir_pkg.sv
// Shared types, register indexes and constants of the joystick frame IR sender.
package jfir_pkg;

    localparam int FRAME_BYTES   = 5;
    localparam int BITS_PER_BYTE = 10;
    localparam int QUEUE_DEPTH   = 2;
    localparam int BYTE_IDX_W    = $clog2(FRAME_BYTES + 1);
    localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE + 1);
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINK_SELECT     = 3'd0,
        CFG_SLOT_OFF_TICKS  = 3'd1,
        CFG_PULSE_TICKS     = 3'd2,
        CFG_FRAME_GAP_TICKS = 3'd3,
        CFG_START_TAG       = 3'd4
    } t_cfg_idx;

    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic        RST_LINK_SELECT = 1'b0;
    localparam logic [7:0]  RST_SLOT_OFF    = 8'd21;
    localparam logic [7:0]  RST_PULSE       = 8'd4;
    localparam logic [15:0] RST_FRAME_GAP   = 16'd5000;
    localparam logic [7:0]  RST_START_TAG   = 8'd35;

    localparam logic [5:0]  PINS_RELEASED   = 6'h3F;

    typedef struct packed {
        logic        link_select;
        logic [7:0]  slot_off_ticks;
        logic [7:0]  pulse_ticks;
        logic [15:0] frame_gap_ticks;
        logic [7:0]  start_tag;
    } t_cfg;

    // Input beat
    typedef struct packed {
        logic       mode;
        logic [9:0] analog0;
        logic [9:0] analog1;
        logic       button0_pin;
        logic       button1_pin;
        logic [3:0] direction_pins;
        logic       uart_ready;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic       ir_led;
        logic [7:0] uart_byte;
        logic       uart_valid;
        logic       frame_last;
        logic       sending;
    } t_out_beat;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic       is_tick;
        logic [9:0] analog0;
        logic [9:0] analog1;
        logic [5:0] pins;      // [5] button1, [4] button0, [3:0] direction
        logic       uart_ready;
    } t_q_entry;

    localparam logic MODE_LATCH = 1'b0;

endpackage

>>> sv/jfir_front.sv
// Front end: configuration registers and classification of incoming items.
module jfir_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [jfir_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [jfir_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output jfir_pkg::t_cfg            o_cfg,
    input  jfir_pkg::t_in_beat        i_in_data,
    output jfir_pkg::t_q_entry        o_entry
);
    import jfir_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register writes; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LINK_SELECT:     n_cfg.link_select     = i_cfg_data[0];
                CFG_SLOT_OFF_TICKS:  n_cfg.slot_off_ticks  = i_cfg_data[7:0];
                CFG_PULSE_TICKS:     n_cfg.pulse_ticks     = i_cfg_data[7:0];
                CFG_FRAME_GAP_TICKS: n_cfg.frame_gap_ticks = i_cfg_data[15:0];
                CFG_START_TAG:       n_cfg.start_tag       = i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.link_select     <= RST_LINK_SELECT;
            r_cfg.slot_off_ticks  <= RST_SLOT_OFF;
            r_cfg.pulse_ticks     <= RST_PULSE;
            r_cfg.frame_gap_ticks <= RST_FRAME_GAP;
            r_cfg.start_tag       <= RST_START_TAG;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Classify: sample latch or time tick, pins packed as the back keeps them
    always_comb begin
        o_entry.is_tick    = (i_in_data.mode != MODE_LATCH);
        o_entry.analog0    = i_in_data.analog0;
        o_entry.analog1    = i_in_data.analog1;
        o_entry.pins       = {i_in_data.button1_pin, i_in_data.button0_pin,
                              i_in_data.direction_pins};
        o_entry.uart_ready = i_in_data.uart_ready;
    end

endmodule

>>> sv/jfir_queue.sv
// Short FIFO between the front end and the frame sender.
module jfir_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  jfir_pkg::t_q_entry i_entry,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output jfir_pkg::t_q_entry o_entry
);
    import jfir_pkg::*;

    t_q_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count,  n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

>>> sv/jfir_back.sv
// Back end: sample store, frame builder, IR/UART send sequencer and result register.
module jfir_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jfir_pkg::t_cfg      i_cfg,
    input  logic                i_q_empty,
    input  jfir_pkg::t_q_entry  i_entry,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output jfir_pkg::t_out_beat o_out_data
);
    import jfir_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_SEND = 3'b010,
        PH_GAP  = 3'b100
    } t_phase;

    logic [9:0]            r_a0, n_a0;
    logic [9:0]            r_a1, n_a1;
    logic [5:0]            r_pins, n_pins;
    logic [7:0]            r_frame [FRAME_BYTES];
    logic [7:0]            n_frame [FRAME_BYTES];
    t_phase                r_phase, n_phase;
    logic [BYTE_IDX_W-1:0] r_byte_idx, n_byte_idx;
    logic [BIT_IDX_W-1:0]  r_bit_idx, n_bit_idx;
    logic [15:0]           r_tick, n_tick;
    logic [7:0]            r_shift, n_shift;
    logic                  r_out_valid;
    t_out_beat             r_out, n_out;

    assign o_pop       = !i_q_empty && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // One item step
    always_comb begin
        logic [7:0]            cur [FRAME_BYTES];
        logic [BYTE_IDX_W-1:0] nxt_idx;
        logic [8:0]            off;
        logic [8:0]            pul;
        logic [16:0]           tick_inc;
        logic                  pulse_on;
        logic                  byte_done;

        n_a0       = r_a0;
        n_a1       = r_a1;
        n_pins     = r_pins;
        n_frame    = r_frame;
        n_phase    = r_phase;
        n_byte_idx = r_byte_idx;
        n_bit_idx  = r_bit_idx;
        n_tick     = r_tick;
        n_shift    = r_shift;
        n_out      = '0;
        cur        = r_frame;
        nxt_idx    = '0;
        off        = '0;
        pul        = '0;
        tick_inc   = '0;
        pulse_on   = 1'b0;
        byte_done  = 1'b0;

        if (!i_entry.is_tick) begin
            // Sample latch
            n_a0          = i_entry.analog0;
            n_a1          = i_entry.analog1;
            n_pins        = i_entry.pins;
            n_out.sending = (r_phase == PH_SEND);
        end else begin
            // Gap countdown
            if (n_phase == PH_GAP) begin
                if (n_tick >= i_cfg.frame_gap_ticks) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_tick = n_tick + 16'd1;
                end
            end
            // Frame start: build all bytes from the held sample
            if (n_phase != PH_SEND && n_phase != PH_GAP) begin
                cur[0] = i_cfg.start_tag;
                cur[1] = {1'b0, ~r_pins[3:0], ~r_pins[4], r_a0[9:8]};
                cur[2] = r_a0[7:0];
                cur[3] = {5'b0, ~r_pins[5], r_a1[9:8]};
                cur[4] = r_a1[7:0];
                n_frame    = cur;
                n_phase    = PH_SEND;
                n_byte_idx = '0;
                n_bit_idx  = '0;
                n_tick     = '0;
                n_shift    = cur[0];
            end

            if (n_phase == PH_SEND) begin
                n_out.sending = 1'b1;
                if (i_cfg.link_select) begin
                    // UART handoff
                    if (i_entry.uart_ready) begin
                        n_out.uart_valid = 1'b1;
                        n_out.uart_byte  = (n_byte_idx < BYTE_IDX_W'(FRAME_BYTES)) ?
                                           cur[n_byte_idx] : 8'd0;
                        byte_done = 1'b1;
                    end
                end else begin
                    // IR bit period: off slot then pulse slot
                    off = (i_cfg.slot_off_ticks == 8'd0) ? 9'd1 : {1'b0, i_cfg.slot_off_ticks};
                    pul = (i_cfg.pulse_ticks == 8'd0) ? 9'd1 : {1'b0, i_cfg.pulse_ticks};
                    if (n_bit_idx == '0) begin
                        pulse_on = 1'b1;
                    end else if (n_bit_idx <= BIT_IDX_W'(8)) begin
                        pulse_on = !n_shift[0];
                    end
                    n_out.ir_led = ({1'b0, n_tick} >= {8'd0, off}) && pulse_on;
                    tick_inc     = {1'b0, n_tick} + 17'd1;
                    n_tick       = tick_inc[15:0];
                    if (tick_inc >= 17'(off + pul)) begin
                        n_tick = '0;
                        if (n_bit_idx >= BIT_IDX_W'(1) && n_bit_idx <= BIT_IDX_W'(8)) begin
                            n_shift = {1'b0, n_shift[7:1]};
                        end
                        n_bit_idx = n_bit_idx + 1'b1;
                        if (n_bit_idx >= BIT_IDX_W'(BITS_PER_BYTE)) begin
                            byte_done = 1'b1;
                        end
                    end
                end

                // Advance to the next byte or close the frame
                if (byte_done) begin
                    n_bit_idx = '0;
                    n_tick    = '0;
                    nxt_idx   = n_byte_idx + 1'b1;
                    if (nxt_idx >= BYTE_IDX_W'(FRAME_BYTES)) begin
                        n_phase          = PH_GAP;
                        n_byte_idx       = '0;
                        n_out.frame_last = 1'b1;
                    end else begin
                        n_byte_idx = nxt_idx;
                        n_shift    = cur[nxt_idx];
                    end
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a0        <= '0;
            r_a1        <= '0;
            r_pins      <= PINS_RELEASED;
            r_phase     <= PH_IDLE;
            r_byte_idx  <= '0;
            r_bit_idx   <= '0;
            r_tick      <= '0;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_a0       <= n_a0;
                r_a1       <= n_a1;
                r_pins     <= n_pins;
                r_phase    <= n_phase;
                r_byte_idx <= n_byte_idx;
                r_bit_idx  <= n_bit_idx;
                r_tick     <= n_tick;
                r_shift    <= n_shift;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: frame bytes and result beat
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_frame <= n_frame;
            r_out   <= n_out;
        end
    end

endmodule

>>> sv/joystick_frame_ir_sender.sv
// Top level of the joystick frame IR sender.
// Every input beat (sample latch or time tick) yields exactly one result beat. The block
// takes one beat per cycle while its queue is not full: the send sequencer finishes
// each beat's step combinationally and parks the result in an output register, while a
// two-entry queue behind the input lets the input side keep accepting while a result
// waits; a beat is thus queued before its step runs. Configuration writes are taken in
// any cycle and should be made only while no beats are outstanding.
module joystick_frame_ir_sender (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [jfir_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [jfir_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  jfir_pkg::t_in_beat             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output jfir_pkg::t_out_beat            o_out_data
);
    import jfir_pkg::*;

    t_cfg     w_cfg;
    t_q_entry w_front_entry;
    t_q_entry w_q_entry;
    logic     w_q_full;
    logic     w_q_empty;
    logic     w_pop;

    assign o_in_ready = !w_q_full;

    // Front end
    jfir_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg),
        .i_in_data   (i_in_data),
        .o_entry     (w_front_entry)
    );

    // Decoupling queue
    jfir_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid && !w_q_full),
        .i_entry (w_front_entry),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_entry (w_q_entry)
    );

    // Send sequencer
    jfir_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_q_empty   (w_q_empty),
        .i_entry     (w_q_entry),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // A UART beat is only produced with the UART link selected
    a_uart_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.uart_valid |-> w_cfg.link_select)
        else $error("uart beat while IR link selected");

    // An LED pulse only comes from the IR link and never with a UART byte
    a_led_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.ir_led |-> !w_cfg.link_select && !o_out_data.uart_valid)
        else $error("IR pulse on UART link");

    // The end of a frame is always flagged inside a frame
    a_last_sending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_last |-> o_out_data.sending)
        else $error("frame end outside a frame");

    // The sequencer only steps on a queued beat
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_empty)
        else $error("pop from empty queue");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the joystick frame IR sender: predicts every result beat.
`timescale 1ns / 1ps

import jfir_pkg::*;

typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEND,
    ST_GAP
} send_state_e;

// Frame predictor plus the queue of result beats still owed by the block
class frame_scoreboard;
    t_cfg        regs;
    logic [9:0]  snap_analog0;
    logic [9:0]  snap_analog1;
    logic [5:0]  snap_pins;     // [5] button1, [4] button0, [3:0] direction
    logic [7:0]  frame_buf [FRAME_BYTES];
    send_state_e state;
    logic [2:0]  byte_pos;
    logic [3:0]  bit_pos;
    logic [15:0] tick_count;
    logic [7:0]  shift_reg;
    t_out_beat   expected_beats [$];
    int unsigned fail_count;

    function new();
        regs = '{link_select: RST_LINK_SELECT, slot_off_ticks: RST_SLOT_OFF,
                 pulse_ticks: RST_PULSE, frame_gap_ticks: RST_FRAME_GAP,
                 start_tag: RST_START_TAG};
        snap_analog0 = '0;
        snap_analog1 = '0;
        snap_pins    = PINS_RELEASED;
        foreach (frame_buf[k]) frame_buf[k] = '0;
        state      = ST_IDLE;
        byte_pos   = '0;
        bit_pos    = '0;
        tick_count = '0;
        shift_reg  = '0;
        fail_count = 0;
    endfunction

    function void write_reg(t_cfg_idx idx, logic [15:0] val);
        case (idx)
            CFG_LINK_SELECT:     regs.link_select     = val[0];
            CFG_SLOT_OFF_TICKS:  regs.slot_off_ticks  = val[7:0];
            CFG_PULSE_TICKS:     regs.pulse_ticks     = val[7:0];
            CFG_FRAME_GAP_TICKS: regs.frame_gap_ticks = val;
            CFG_START_TAG:       regs.start_tag       = val[7:0];
            default: ;
        endcase
    endfunction

    // Build the five frame bytes from the held sample (pins are active low)
    function void load_frame();
        frame_buf[0] = regs.start_tag;
        frame_buf[1] = {1'b0, ~snap_pins[3:0], ~snap_pins[4], snap_analog0[9:8]};
        frame_buf[2] = snap_analog0[7:0];
        frame_buf[3] = {5'b0, ~snap_pins[5], snap_analog1[9:8]};
        frame_buf[4] = snap_analog1[7:0];
        state      = ST_SEND;
        byte_pos   = '0;
        bit_pos    = '0;
        tick_count = '0;
        shift_reg  = frame_buf[0];
    endfunction

    // Step to the next byte; returns 1 when the frame is done
    function bit next_byte();
        bit_pos    = '0;
        tick_count = '0;
        byte_pos   = byte_pos + 3'd1;
        if (byte_pos >= FRAME_BYTES) begin
            state    = ST_GAP;
            byte_pos = '0;
            return 1'b1;
        end
        shift_reg = frame_buf[byte_pos];
        return 1'b0;
    endfunction

    function void note_beat(t_in_beat beat);
        t_out_beat res;
        int        off_len;
        int        pulse_len;
        logic      pulse_on;
        res = '0;
        if (beat.mode == MODE_LATCH) begin
            snap_analog0 = beat.analog0;
            snap_analog1 = beat.analog1;
            snap_pins    = {beat.button1_pin, beat.button0_pin, beat.direction_pins};
            res.sending  = (state == ST_SEND);
        end else begin
            // gap countdown, then a new frame starts on this same tick
            if (state == ST_GAP) begin
                if (tick_count >= regs.frame_gap_ticks) state = ST_IDLE;
                else tick_count = tick_count + 16'd1;
            end
            if (state == ST_IDLE) load_frame();
            if (state == ST_SEND) begin
                res.sending = 1'b1;
                if (regs.link_select) begin
                    if (beat.uart_ready) begin
                        res.uart_valid = 1'b1;
                        res.uart_byte  = frame_buf[byte_pos];
                        res.frame_last = next_byte();
                    end
                end else begin
                    // zero-length slots count as one tick
                    off_len   = (regs.slot_off_ticks == 0) ? 1 : int'(regs.slot_off_ticks);
                    pulse_len = (regs.pulse_ticks == 0) ? 1 : int'(regs.pulse_ticks);
                    if (bit_pos == 0)      pulse_on = 1'b1;
                    else if (bit_pos <= 8) pulse_on = ~shift_reg[0];
                    else                   pulse_on = 1'b0;
                    res.ir_led = (int'(tick_count) >= off_len) && pulse_on;
                    tick_count = tick_count + 16'd1;
                    if (int'(tick_count) >= off_len + pulse_len) begin
                        tick_count = '0;
                        if (bit_pos >= 1 && bit_pos <= 8) shift_reg = shift_reg >> 1;
                        bit_pos = bit_pos + 4'd1;
                        if (bit_pos >= BITS_PER_BYTE) res.frame_last = next_byte();
                    end
                end
            end
        end
        expected_beats.push_back(res);
    endfunction

    function void check_beat(t_out_beat got);
        t_out_beat want;
        if (expected_beats.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("result beat with nothing expected: %p", got);
            return;
        end
        want = expected_beats.pop_front();
        if (got.ir_led !== want.ir_led || got.uart_byte !== want.uart_byte ||
            got.uart_valid !== want.uart_valid || got.frame_last !== want.frame_last ||
            got.sending !== want.sending) begin
            fail_count++;
            if (fail_count <= 10)
                $display({"result mismatch: expected led=%0b byte=%02h valid=%0b last=%0b ",
                          "sending=%0b, got led=%0b byte=%02h valid=%0b last=%0b sending=%0b"},
                         want.ir_led, want.uart_byte, want.uart_valid, want.frame_last,
                         want.sending, got.ir_led, got.uart_byte, got.uart_valid,
                         got.frame_last, got.sending);
        end
    endfunction
endclass

module testbench;

    localparam logic MODE_TICK = ~MODE_LATCH;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    t_cfg_idx  i_cfg_index = CFG_LINK_SELECT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out_data;

    bit              steady = 1'b0;   // no idling on either side while set
    frame_scoreboard sb     = new();

    joystick_frame_ir_sender DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: check each accepted beat, stall now and then
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_beat(o_out_data);
        i_out_ready <= steady || ($urandom_range(0, 99) >= 6);
    end

    function automatic logic [9:0] pick_analog();
        case ($urandom_range(0, 7))
            0:       return 10'h000;
            1:       return 10'h3FF;
            default: return 10'($urandom);
        endcase
    endfunction

    function automatic t_in_beat latch_beat(logic [9:0] a0, logic [9:0] a1, logic b0,
                                            logic b1, logic [3:0] dirs);
        t_in_beat beat;
        beat = '{mode: MODE_LATCH, analog0: a0, analog1: a1, button0_pin: b0,
                 button1_pin: b1, direction_pins: dirs, uart_ready: 1'($urandom)};
        return beat;
    endfunction

    // Sample fields of a tick beat are noise the block must not use
    function automatic t_in_beat tick_beat(logic ready);
        t_in_beat beat;
        beat = '{mode: MODE_TICK, analog0: 10'($urandom), analog1: 10'($urandom),
                 button0_pin: 1'($urandom), button1_pin: 1'($urandom),
                 direction_pins: 4'($urandom), uart_ready: ready};
        return beat;
    endfunction

    function automatic t_in_beat random_beat();
        if ($urandom_range(0, 99) < 12)
            return latch_beat(pick_analog(), pick_analog(), 1'($urandom), 1'($urandom),
                              4'($urandom));
        return tick_beat($urandom_range(0, 99) < 75);
    endfunction

    // Slot lengths: mostly short so frames complete, with both extremes
    function automatic logic [7:0] pick_slot();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'hFF;
            2:       return 8'($urandom_range(1, 255));
            default: return 8'($urandom_range(1, 3));
        endcase
    endfunction

    function automatic t_cfg random_settings();
        t_cfg c;
        c.link_select    = 1'($urandom);
        c.slot_off_ticks = pick_slot();
        c.pulse_ticks    = pick_slot();
        case ($urandom_range(0, 9))
            0:       c.frame_gap_ticks = 16'd0;
            1:       c.frame_gap_ticks = 16'hFFFF;
            2:       c.frame_gap_ticks = 16'($urandom);
            default: c.frame_gap_ticks = 16'($urandom_range(0, 12));
        endcase
        c.start_tag = 8'($urandom);
        return c;
    endfunction

    // One register write; valid is left high for back-to-back writes
    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic write_config(input t_cfg c);
        write_reg(CFG_LINK_SELECT, {15'd0, c.link_select});
        write_reg(CFG_SLOT_OFF_TICKS, {8'd0, c.slot_off_ticks});
        write_reg(CFG_PULSE_TICKS, {8'd0, c.pulse_ticks});
        write_reg(CFG_FRAME_GAP_TICKS, c.frame_gap_ticks);
        write_reg(CFG_START_TAG, {8'd0, c.start_tag});
        i_cfg_valid <= 1'b0;
    endtask

    // Input side: optional idle cycles, then hold the beat until accepted
    task automatic send_beat(input t_in_beat beat);
        if (!steady && $urandom_range(0, 99) < 6) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 30);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_beat(beat);
    endtask

    // Hold off the input side until every owed result beat is back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_beats.size() != 0);
    endtask

    initial begin
        t_cfg settings;
        int   random_items;
        int   phase_no;
        int   phase_len;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // UART link: full frame, stalled ready, zero gap, latch while sending
        settings = '{link_select: 1'b1, slot_off_ticks: 8'd1, pulse_ticks: 8'd1,
                     frame_gap_ticks: 16'd0, start_tag: 8'hFF};
        write_config(settings);
        send_beat(latch_beat(10'h3FF, 10'h000, 1'b0, 1'b1, 4'h0));
        send_beat(tick_beat(1'b0));
        repeat (6) send_beat(tick_beat(1'b1));
        send_beat(latch_beat(10'h000, 10'h3FF, 1'b1, 1'b0, 4'hF));
        repeat (5) send_beat(tick_beat(1'b1));
        drain();

        // IR link picks up mid-frame, zero slot lengths act as one tick
        settings = '{link_select: 1'b0, slot_off_ticks: 8'd0, pulse_ticks: 8'd0,
                     frame_gap_ticks: 16'd0, start_tag: 8'h00};
        write_config(settings);
        repeat (10) send_beat(tick_beat(1'($urandom)));
        drain();

        // Random phases; the first one uses the longest slots and gap
        settings = '{link_select: 1'b0, slot_off_ticks: 8'hFF, pulse_ticks: 8'hFF,
                     frame_gap_ticks: 16'hFFFF, start_tag: 8'($urandom)};
        random_items = 0;
        phase_no     = 0;
        while (random_items < 750) begin
            if (phase_no > 0) settings = random_settings();
            write_config(settings);
            steady    = (phase_no == 3);
            phase_len = $urandom_range(40, 90);
            repeat (phase_len) begin
                send_beat(random_beat());
                random_items++;
            end
            drain();
            phase_no++;
        end
        steady = 1'b0;

        repeat (20) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
